// ===== design/qspd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qspd_pkg
// Shared constants and types of the query string percent decoder: the
// special characters, the result kinds and the command word that travels
// from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package qspd_pkg;

  // Characters with a meaning of their own in an encoded query string
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;

  // Result kinds
  localparam logic [1:0] KIND_NAME     = 2'd0;
  localparam logic [1:0] KIND_VALUE    = 2'd1;
  localparam logic [1:0] KIND_PAIR_END = 2'd2;
  localparam logic [1:0] KIND_STR_END  = 2'd3;

  // Most results one input byte can cause
  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // Queue between front and back end
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One command word: the results caused by one input byte, in order
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [MAX_RESULTS-1:0][7:0]       bytes;
    logic [MAX_RESULTS-1:0][1:0]       kinds;
  } qspd_cmd_t;

endpackage

// ===== design/qspd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qspd_front
// Front end: accept raw bytes, run the escape and pair state, and pack the
// results caused by each byte into one command word for the queue.
// ----------------------------------------------------------------------------
module qspd_front
  import qspd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            push_valid,
  input  logic            push_ready,
  output qspd_cmd_t       push_cmd
);

  typedef struct packed {
    logic [1:0] held_count;
    logic [7:0] held_digit;
    logic       in_value_part;
    logic       name_nonempty;
  } dec_state_t;

  typedef struct packed {
    dec_state_t st;
    qspd_cmd_t  cmd;
  } work_t;

  dec_state_t state;
  work_t      work;
  logic       accept;

  // {valid, value} of a hex digit character, either case
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic work_t put(input work_t w, input logic [7:0] b, input logic [1:0] k);
    work_t r;
    r = w;
    if (w.cmd.count < CNT_W'(MAX_RESULTS)) begin
      r.cmd.bytes[w.cmd.count[IDX_W-1:0]] = b;
      r.cmd.kinds[w.cmd.count[IDX_W-1:0]] = k;
      r.cmd.count = w.cmd.count + CNT_W'(1);
    end
    return r;
  endfunction

  // Drop zero bytes; value bytes of a pair without a name are dropped too
  function automatic work_t emit_data(input work_t w, input logic [7:0] b);
    work_t r;
    r = w;
    if (b != 8'h00) begin
      if (w.st.in_value_part) begin
        if (w.st.name_nonempty) r = put(w, b, KIND_VALUE);
      end else begin
        r = put(w, b, KIND_NAME);
        r.st.name_nonempty = 1'b1;
      end
    end
    return r;
  endfunction

  // Emit a pending '%' and held digit literally
  function automatic work_t flush_held(input work_t w);
    work_t r;
    r = w;
    if (w.st.held_count == 2'd1) begin
      r = emit_data(r, CH_PERCENT);
    end else if (w.st.held_count == 2'd2) begin
      r = emit_data(r, CH_PERCENT);
      r = emit_data(r, w.st.held_digit);
    end
    r.st.held_count = 2'd0;
    r.st.held_digit = 8'h00;
    return r;
  endfunction

  function automatic work_t end_pair(input work_t w);
    work_t r;
    r = w;
    if (w.st.name_nonempty) r = put(r, 8'h00, KIND_PAIR_END);
    r.st.in_value_part = 1'b0;
    r.st.name_nonempty = 1'b0;
    return r;
  endfunction

  // Handle a byte with no escape pending
  function automatic work_t fresh(input work_t w, input logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_PERCENT) begin
      r.st.held_count = 2'd1;
    end else if (c == CH_AMP) begin
      r = end_pair(r);
    end else if (c == CH_EQUALS && !w.st.in_value_part) begin
      r.st.in_value_part = 1'b1;
    end else if (c == CH_PLUS) begin
      r = emit_data(r, CH_SPACE);
    end else begin
      r = emit_data(r, c);
    end
    return r;
  endfunction

  always_comb begin
    logic [4:0] hv;
    logic [4:0] hi;
    hv = hex_val(in_byte);
    hi = hex_val(state.held_digit);
    work.st  = state;
    work.cmd = '0;
    unique case (state.held_count)
      2'd1: begin
        if (hv[4]) begin
          work.st.held_digit = in_byte;
          work.st.held_count = 2'd2;
        end else begin
          work = flush_held(work);
          work = fresh(work, in_byte);
        end
      end
      2'd2: begin
        if (hv[4]) begin
          work.st.held_count = 2'd0;
          work.st.held_digit = 8'h00;
          work = emit_data(work, {hi[3:0], hv[3:0]});
        end else begin
          work = flush_held(work);
          work = fresh(work, in_byte);
        end
      end
      default: begin
        work.st.held_count = 2'd0;
        work = fresh(work, in_byte);
      end
    endcase
    if (in_last) begin
      work = flush_held(work);
      work = end_pair(work);
      work = put(work, 8'h00, KIND_STR_END);
      work.st = '0;
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (work.cmd.count != '0);
  assign push_cmd   = work.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= work.st;
    end
  end

endmodule

// ===== design/qspd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qspd_queue
// Short command queue between front and back end; push and pop may share
// a cycle.
// ----------------------------------------------------------------------------
module qspd_queue
  import qspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  qspd_cmd_t  push_cmd,
  output logic       pop_valid,
  input  logic       pop_ready,
  output qspd_cmd_t  pop_cmd
);

  qspd_cmd_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/qspd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qspd_back
// Back end: take one command word at a time and hand out its results one per
// cycle, out_ready permitting, via the output register, marking the final one.
// ----------------------------------------------------------------------------
module qspd_back
  import qspd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  qspd_cmd_t   pop_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  qspd_cmd_t        cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             cur_last;
  logic             out_load;
  logic             cur_finish;

  assign cur_last   = (CNT_W'(idx) == (cur.count - CNT_W'(1)));
  assign out_load   = cur_valid && (!out_valid || out_ready);
  assign cur_finish = out_load && cur_last;
  assign pop_ready  = !cur_valid || cur_finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop_valid && pop_ready) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_finish) begin
        cur_valid <= 1'b0;
      end else if (out_load) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) cur <= pop_cmd;
    if (out_load) begin
      out_byte <= cur.bytes[idx];
      out_kind <= cur.kinds[idx];
      out_last <= cur_last;
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (CNT_W'(idx) < cur.count))
    else $error("result index beyond command count");

  a_str_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_STR_END) |-> out_last)
    else $error("string end not marked as final result");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_PAIR_END || out_kind == KIND_STR_END))
      |-> (out_byte == 8'h00))
    else $error("marker result carries a non-zero byte");
`endif

endmodule

// ===== design/query_string_percent_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_string_percent_decoder
// Streaming decoder for a URL-encoded query string, one raw byte per word.
// ----------------------------------------------------------------------------
// Raw bytes enter on the input channel, in_last high on the final byte. The
// first raw '=' of a pair moves from name to value, a raw '&' ends the pair;
// '+' decodes to a space and '%' with two hex digits to one byte, a '%'
// without two hex digits passes through literally, zero bytes are dropped
// and a pair with an empty name gives no output at all. Each result word is
// a name byte, a value byte, a pair end or a string end (out_kind 0..3),
// with out_last high on the final result caused by an input byte. Rate: an
// input byte is taken every cycle while out_ready is high and each byte gives
// at most one result; the results of a byte (up to five, e.g. a broken
// escape on the final byte) leave one per cycle, out_ready permitting,
// through the back end's output register. A byte causing no result (a held
// '%' or hex digit, the '=' that starts the value) is taken on input only.
// An input byte passes the queue memory, the back end's command register
// and the output register before its first result appears. The two-deep
// queue lets the front end take bytes while the back end stalls, until full.
// ----------------------------------------------------------------------------
module query_string_percent_decoder
  import qspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  logic      push_valid;
  logic      push_ready;
  qspd_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  qspd_cmd_t pop_cmd;

  // Classify each byte and pack its results into a command word
  qspd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Hold command words while the back end is busy or stalled
  qspd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Serialise each command word into result words
  qspd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule
